### hdl/encc_pkg.sv
// Package for the elevator nearest-call controller: entry and control types,
// register map, reset values and the goal selection function.
// No dependencies.
`timescale 1ns / 1ps

package encc_pkg;

  localparam int FloorsDefault     = 5;
  localparam int TableDepthDefault = 16;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_FLOOR_PITCH = 3'd0;
  localparam logic [2:0] REG_STEP_SIZE   = 3'd1;
  localparam logic [2:0] REG_LOAD_TICKS  = 3'd2;
  localparam logic [2:0] REG_IDLE_TICKS  = 3'd3;
  localparam logic [2:0] REG_CAPACITY    = 3'd4;

  localparam logic [9:0]  PITCH_RESET    = 10'd100;
  localparam logic [7:0]  STEP_RESET     = 8'd6;
  localparam logic [7:0]  LOAD_RESET     = 8'd15;
  localparam logic [15:0] IDLE_RESET     = 16'd312;
  localparam logic [6:0]  CAPACITY_RESET = 7'd8;

  // Request types.
  localparam logic [1:0] REQ_TICK      = 2'd0;
  localparam logic [1:0] REQ_HALL_CALL = 2'd1;
  localparam logic [1:0] REQ_PASSENGER = 2'd2;

  // Travel direction codes.
  localparam logic [1:0] DIR_IDLE = 2'b00;
  localparam logic [1:0] DIR_UP   = 2'b01;
  localparam logic [1:0] DIR_DOWN = 2'b11;

  typedef struct packed {
    logic       valid;
    logic       in_car;
    logic [2:0] src_fl;
    logic [2:0] dst_fl;
  } entry_t;

  typedef struct packed {
    logic rotate;
    logic collapse;
  } cell_ctrl_t;

  typedef struct packed {
    logic [2:0] aim;
    logic [1:0] dir;
  } goal_t;

  // Nearest set floor to stop; the lowest floor wins a tie.
  function automatic logic [2:0] nearest(input logic [7:0] mask, input logic [2:0] stop);
    logic [2:0] best;
    logic [3:0] bestd;
    logic [3:0] d;
    best  = stop;
    bestd = 4'd9;
    for (int f = 0; f < 8; f++) begin
      d = (3'(f) > stop) ? 4'(3'(f) - stop) : 4'(stop - 3'(f));
      if (mask[f] && d < bestd) begin
        bestd = d;
        best  = 3'(f);
      end
    end
    return best;
  endfunction

  // Drop-offs come first, then pickups; with nothing pending the car idles.
  function automatic goal_t choose_goal(input logic [7:0] drop, input logic [7:0] pick,
                                        input logic [2:0] stop, input logic [2:0] aim_cur);
    goal_t      g;
    logic [7:0] m;
    m = (drop != 8'd0) ? drop : pick;
    if (m == 8'd0) begin
      g.aim = aim_cur;
      g.dir = DIR_IDLE;
    end else begin
      g.aim = nearest(m, stop);
      g.dir = (g.aim > stop) ? DIR_UP : DIR_DOWN;
    end
    return g;
  endfunction

endpackage

### hdl/encc_req_if.sv
// Request channel: valid/ready handshake carrying one request item.
// No dependencies.
`timescale 1ns / 1ps

interface encc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [2:0] from_floor;
  logic [2:0] to_floor;

  modport source (output valid, req_type, from_floor, to_floor, input ready);
  modport sink (input valid, req_type, from_floor, to_floor, output ready);
endinterface

### hdl/encc_res_if.sv
// Result channel: valid/ready handshake carrying one status item.
// No dependencies.
`timescale 1ns / 1ps

interface encc_res_if;
  logic              valid;
  logic              ready;
  logic [2:0]        current_floor;
  logic [2:0]        goal_floor;
  logic [12:0]       car_position;
  logic signed [1:0] travel_direction;
  logic              loading_now;
  logic [6:0]        rider_count;
  logic [6:0]        waiting_count;
  logic [7:0]        pickup_mask;
  logic [7:0]        dropoff_mask;
  logic              request_dropped;

  modport source (output valid, current_floor, goal_floor, car_position, travel_direction,
                  loading_now, rider_count, waiting_count, pickup_mask, dropoff_mask,
                  request_dropped, input ready);
  modport sink (input valid, current_floor, goal_floor, car_position, travel_direction,
                loading_now, rider_count, waiting_count, pickup_mask, dropoff_mask,
                request_dropped, output ready);
endinterface

### hdl/elevator_nearest_call_controller.sv
// Elevator controller for one car with nearest-call scheduling. Each request
// (tick, hall call or passenger request) yields one status item. A hall call, a
// passenger request or an undefined request goes from acceptance straight to S_OUT,
// and a tick that moves the car or counts a loading tick passes S_CHECK first.
// A tick that ends a loading period walks the passenger cell chain three times
// (rider exit, boarding, compaction), one cell a cycle, then passes S_FINISH and
// S_CHECK. S_OUT registers the result once the result channel is free; the next
// request is accepted only from the cycle after the result is registered.
`timescale 1ns / 1ps

module elevator_nearest_call_controller
  import encc_pkg::*;
#(
  parameter int FLOORS      = FloorsDefault,
  parameter int TABLE_DEPTH = TableDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  encc_req_if.sink    req,
  encc_res_if.source  res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_PASS_A, S_PASS_B, S_PASS_C, S_FINISH, S_CHECK, S_OUT
  } state_t;

  // Configuration registers.
  logic [9:0]  floor_pitch;
  logic [7:0]  step_size;
  logic [7:0]  load_ticks;
  logic [15:0] idle_ticks;
  logic [6:0]  capacity;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_pitch <= PITCH_RESET;
      step_size   <= STEP_RESET;
      load_ticks  <= LOAD_RESET;
      idle_ticks  <= IDLE_RESET;
      capacity    <= CAPACITY_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_FLOOR_PITCH: floor_pitch <= pwdata[9:0];
        REG_STEP_SIZE:   step_size   <= pwdata[7:0];
        REG_LOAD_TICKS:  load_ticks  <= pwdata[7:0];
        REG_IDLE_TICKS:  idle_ticks  <= pwdata[15:0];
        REG_CAPACITY:    capacity    <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FLOOR_PITCH: prdata = 32'(floor_pitch);
      REG_STEP_SIZE:   prdata = 32'(step_size);
      REG_LOAD_TICKS:  prdata = 32'(load_ticks);
      REG_IDLE_TICKS:  prdata = 32'(idle_ticks);
      REG_CAPACITY:    prdata = 32'(capacity);
      default:         prdata = '0;
    endcase
  end

  // Controller state.
  state_t              state;
  logic [13:0]         position;
  logic [2:0]          stop_floor;
  logic [2:0]          aim_floor;
  logic [1:0]          dir;
  logic                load_flag;
  logic [7:0]          load_counter;
  logic [15:0]         idle_counter;
  logic [FLOORS-1:0]   pickup_bits;
  logic [FLOORS-1:0]   dropoff_bits;
  logic [CW-1:0]       rider_cnt;
  logic [CW-1:0]       wait_cnt;
  logic [IW-1:0]       pass_cnt;
  logic                left_flag;
  logic                waiting_flag;
  logic                dropped;

  // Cell chain.
  cell_ctrl_t          cell_ctrl;
  entry_t              cell_q     [TABLE_DEPTH];
  entry_t              cell_up    [TABLE_DEPTH];
  logic                cell_hole  [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] cell_load;
  entry_t              new_entry;
  entry_t              tail_in;
  entry_t              head;
  entry_t              proc_a;
  entry_t              proc_b;
  logic                leave_now;
  logic                board_now;

  logic [CW-1:0]       fill;
  logic                append;

  assign fill = rider_cnt + wait_cnt;
  assign head = cell_q[0];

  assign cell_ctrl.rotate   = (state == S_PASS_A) || (state == S_PASS_B);
  assign cell_ctrl.collapse = (state == S_PASS_C);

  assign new_entry.valid  = 1'b1;
  assign new_entry.in_car = 1'b0;
  assign new_entry.src_fl = req.from_floor;
  assign new_entry.dst_fl = req.to_floor;

  // Rider exit pass and boarding pass decisions on the entry at the head.
  always_comb begin
    leave_now = head.valid && head.in_car && (head.dst_fl == stop_floor);
    proc_a    = head;
    if (leave_now) begin
      proc_a = '0;
    end
    board_now = head.valid && !head.in_car && (head.src_fl == stop_floor) &&
                (7'(rider_cnt) < capacity);
    proc_b    = head;
    if (board_now) begin
      proc_b.in_car = 1'b1;
    end
    unique case (state)
      S_PASS_A: tail_in = proc_a;
      S_PASS_B: tail_in = proc_b;
      default:  tail_in = '0;
    endcase
  end

  assign cell_hole[0] = 1'b0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == TABLE_DEPTH - 1) begin : g_top
      assign cell_up[i] = tail_in;
    end else begin : g_mid
      assign cell_up[i] = cell_q[i+1];
    end
    assign cell_load[i] = append && (fill[IW-1:0] == IW'(i));

    encc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (cell_ctrl),
      .load       (cell_load[i]),
      .load_entry (new_entry),
      .upper      (cell_up[i]),
      .hole_in    (cell_hole[i]),
      .hole_out   (cell_hole[i+1]),
      .q          (cell_q[i])
    );
  end

  // Request decode in the idle state.
  logic              accept;
  logic              floors_ok;
  logic              from_ok;
  logic              table_full;
  logic              add_pick;
  logic [FLOORS-1:0] pick_new;
  goal_t             goal_add;
  goal_t             goal_fin;

  assign accept     = req.valid && req.ready;
  assign req.ready  = (state == S_IDLE);
  assign from_ok    = 4'(req.from_floor) < 4'(FLOORS);
  assign floors_ok  = from_ok && (4'(req.to_floor) < 4'(FLOORS));
  assign table_full = (32'(fill) >= 32'(TABLE_DEPTH));
  assign append     = accept && (req.req_type == REQ_PASSENGER) && floors_ok &&
                      (req.from_floor != req.to_floor) && !table_full;
  assign add_pick   = append || (accept && (req.req_type == REQ_HALL_CALL) && from_ok);
  assign pick_new   = pickup_bits | (FLOORS'(1) << req.from_floor);
  assign goal_add   = choose_goal(8'(dropoff_bits), 8'(pick_new), stop_floor, aim_floor);
  assign goal_fin   = choose_goal(8'(dropoff_bits), 8'(pickup_bits), stop_floor, aim_floor);

  // Car motion for one tick.
  logic [12:0]        target;
  logic signed [15:0] tgt_s;
  logic signed [15:0] pos_s;
  logic signed [15:0] step_s;
  logic signed [15:0] pos_mv;
  logic signed [15:0] delta;
  logic               snap;
  logic signed [15:0] pos_fin;
  logic [8:0]         load_next;

  always_comb begin
    target = 13'(aim_floor) * 13'(floor_pitch);
    tgt_s  = 16'(target);
    pos_s  = 16'(position);
    step_s = 16'(step_size);
    if (pos_s < tgt_s) begin
      pos_mv = pos_s + step_s;
    end else if (pos_s > tgt_s) begin
      pos_mv = pos_s - step_s;
    end else begin
      pos_mv = pos_s;
    end
    delta   = (pos_mv > tgt_s) ? (pos_mv - tgt_s) : (tgt_s - pos_mv);
    snap    = delta < step_s;
    pos_fin = snap ? tgt_s : pos_mv;
    if (pos_fin < 16'sd0) begin
      pos_fin = 16'sd0;
    end
    load_next = 9'(load_counter) + 9'd1;
  end

  logic last_cell;
  assign last_cell = (pass_cnt == IW'(TABLE_DEPTH - 1));

  logic res_free;
  assign res_free = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      position     <= '0;
      stop_floor   <= '0;
      aim_floor    <= '0;
      dir          <= DIR_IDLE;
      load_flag    <= 1'b0;
      load_counter <= '0;
      idle_counter <= '0;
      pickup_bits  <= '0;
      dropoff_bits <= '0;
      rider_cnt    <= '0;
      wait_cnt     <= '0;
      pass_cnt     <= '0;
      left_flag    <= 1'b0;
      waiting_flag <= 1'b0;
      dropped      <= 1'b0;
      res.valid    <= 1'b0;
    end else begin
      if (res.valid && res.ready && state != S_OUT) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            dropped <= (req.req_type == REQ_PASSENGER) &&
                       (!floors_ok || ((req.from_floor != req.to_floor) && table_full));
            state   <= S_OUT;
            if (add_pick) begin
              pickup_bits  <= pick_new;
              idle_counter <= '0;
              if (dir == DIR_IDLE) begin
                aim_floor <= goal_add.aim;
                dir       <= goal_add.dir;
              end
            end
            if (append) begin
              wait_cnt <= wait_cnt + CW'(1);
            end
            if (req.req_type == REQ_TICK) begin
              state <= S_CHECK;
              if (idle_counter != 16'hFFFF) begin
                idle_counter <= idle_counter + 16'd1;
              end
              if (!load_flag) begin
                position <= pos_fin[13:0];
                if (snap) begin
                  stop_floor   <= aim_floor;
                  load_flag    <= 1'b1;
                  load_counter <= '0;
                end
              end else if (load_next > 9'(load_ticks)) begin
                load_counter <= '0;
                load_flag    <= 1'b0;
                left_flag    <= 1'b0;
                waiting_flag <= 1'b0;
                pass_cnt     <= '0;
                state        <= S_PASS_A;
              end else begin
                load_counter <= load_next[7:0];
              end
            end
          end
        end
        S_PASS_A: begin
          if (leave_now) begin
            left_flag <= 1'b1;
            rider_cnt <= rider_cnt - CW'(1);
          end
          pass_cnt <= pass_cnt + IW'(1);
          if (last_cell) begin
            pass_cnt <= '0;
            state    <= S_PASS_B;
            if (left_flag || leave_now) begin
              dropoff_bits[stop_floor] <= 1'b0;
              idle_counter             <= '0;
            end
          end
        end
        S_PASS_B: begin
          if (board_now) begin
            rider_cnt                  <= rider_cnt + CW'(1);
            wait_cnt                   <= wait_cnt - CW'(1);
            dropoff_bits[head.dst_fl]  <= 1'b1;
            idle_counter               <= '0;
          end
          if (proc_b.valid && !proc_b.in_car && (proc_b.src_fl == stop_floor)) begin
            waiting_flag <= 1'b1;
          end
          pass_cnt <= pass_cnt + IW'(1);
          if (last_cell) begin
            pass_cnt <= '0;
            state    <= S_PASS_C;
          end
        end
        S_PASS_C: begin
          if (!waiting_flag) begin
            pickup_bits[stop_floor] <= 1'b0;
          end
          pass_cnt <= pass_cnt + IW'(1);
          if (last_cell) begin
            pass_cnt <= '0;
            state    <= S_FINISH;
          end
        end
        S_FINISH: begin
          aim_floor <= goal_fin.aim;
          dir       <= goal_fin.dir;
          state     <= S_CHECK;
        end
        S_CHECK: begin
          // An idle car away from the lobby heads back to floor 0.
          if (stop_floor != 3'd0 && dropoff_bits == '0 && pickup_bits == '0 &&
              dir == DIR_IDLE && idle_counter >= idle_ticks) begin
            aim_floor    <= 3'd0;
            dir          <= DIR_DOWN;
            idle_counter <= '0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (res_free) begin
            res.valid            <= 1'b1;
            res.current_floor    <= stop_floor;
            res.goal_floor       <= aim_floor;
            res.car_position     <= position[12:0];
            res.travel_direction <= dir;
            res.loading_now      <= load_flag;
            res.rider_count      <= 7'(rider_cnt);
            res.waiting_count    <= 7'(wait_cnt);
            res.pickup_mask      <= 8'(pickup_bits);
            res.dropoff_mask     <= 8'(dropoff_bits);
            res.request_dropped  <= dropped;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/encc_cell.sv
// One passenger table cell: holds an entry and passes it to its lower neighbor.
// Depends on encc_pkg.
`timescale 1ns / 1ps

module encc_cell
  import encc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic       load,
  input  entry_t     load_entry,
  input  entry_t     upper,
  input  logic       hole_in,
  output logic       hole_out,
  output entry_t     q
);

  // A hole here or below pulls every entry above it down one place.
  assign hole_out = hole_in | ~q.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (load) begin
      q <= load_entry;
    end else if (ctrl.rotate || (ctrl.collapse && hole_out)) begin
      q <= upper;
    end
  end

endmodule
